// ===== design/linear_buffer_range_allocator_unit_assert.svh =====
// Assertion macros included by the allocator unit.
`ifndef LINEAR_BUFFER_RANGE_ALLOCATOR_UNIT_ASSERT_SVH
`define LINEAR_BUFFER_RANGE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define LBRA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define LBRA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LBRA_ASSERT_IMP(label, clk, rst, ante, cons)
`define LBRA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/lbra_pkg.sv =====
package lbra_pkg;
   // Field widths.
   localparam int DATA_W   = 32;
   localparam int TAG_W    = 16;
   localparam int ALIGN_W  = 17;
   localparam int LIVE_W   = 9;
   localparam int STATUS_W = 2;

   // Request kinds.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE  = 2'd2;

   // Register index of buffer_size.
   localparam logic CSR_BUFFER_SIZE = 1'b0;
endpackage

// ===== design/lbra_rem.sv =====
// Restoring remainder unit: one dividend bit per cycle.
module lbra_rem (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [lbra_pkg::DATA_W-1:0]      dividend,
   input  logic [lbra_pkg::ALIGN_W-1:0]     divisor,
   output logic                             done,
   output logic [lbra_pkg::ALIGN_W-1:0]     remainder
);
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [4:0]                      cnt_ff, cnt_in;
   logic [lbra_pkg::DATA_W-1:0]     num_ff, num_in;
   logic [lbra_pkg::ALIGN_W-1:0]    rem_ff, rem_in;
   logic [lbra_pkg::ALIGN_W-1:0]    div_ff, div_in;
   logic [lbra_pkg::ALIGN_W:0]      trial;

   // One shift-and-subtract step per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, num_ff[lbra_pkg::DATA_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = lbra_pkg::ALIGN_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[lbra_pkg::ALIGN_W-1:0];
         end
         num_in = {num_ff[lbra_pkg::DATA_W-2:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

// ===== design/lbra_slot_mem.sv =====
// Per-slot store: tag with live bit, and reserved size. One write, one read.
module lbra_slot_mem #(
   parameter int MAX_SLOTS = 256,
   parameter int SLOT_W    = 8
) (
   input  logic                          clock,
   input  logic [SLOT_W-1:0]             rd_addr,
   output logic [lbra_pkg::TAG_W-1:0]    rd_tag,
   output logic                          rd_live,
   output logic [lbra_pkg::DATA_W-1:0]   rd_reserved,
   input  logic [SLOT_W-1:0]             wr_addr,
   input  logic                          wr_meta_en,
   input  logic [lbra_pkg::TAG_W-1:0]    wr_tag,
   input  logic                          wr_live,
   input  logic                          wr_res_en,
   input  logic [lbra_pkg::DATA_W-1:0]   wr_reserved
);
   logic [lbra_pkg::TAG_W:0]    meta_mem [MAX_SLOTS];
   logic [lbra_pkg::DATA_W-1:0] res_mem  [MAX_SLOTS];
   logic [lbra_pkg::TAG_W:0]    meta_rd_ff;
   logic [lbra_pkg::DATA_W-1:0] res_rd_ff;

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_meta_en) begin
         meta_mem[wr_addr] <= {wr_live, wr_tag};
      end
      if (wr_res_en) begin
         res_mem[wr_addr] <= wr_reserved;
      end
      meta_rd_ff <= meta_mem[rd_addr];
      res_rd_ff  <= res_mem[rd_addr];
   end

   assign rd_live     = meta_rd_ff[lbra_pkg::TAG_W];
   assign rd_tag      = meta_rd_ff[lbra_pkg::TAG_W-1:0];
   assign rd_reserved = res_rd_ff;
endmodule

// ===== design/linear_buffer_range_allocator_unit.sv =====
// A free passes through FREE_RD and FREE_CHK; an allocate visits SCAN_FL, SCAN_SL and SCAN_CHK
// per free-list entry scanned, taking HIT_MV on a reuse hit, or falls through to the bump path:
// DIV_GO, DIV_WAIT on the bit-serial alignment remainder unit, then BUMP.
// Throughput: one request at a time; the next is taken once the current result is registered.
// Reset is synchronous: counters and stack top clear, buffer_size returns to 65536.
// The slot and free-list memories need no clearing pass; stale entries are never acted on.
module linear_buffer_range_allocator_unit #(
   parameter int MAX_SLOTS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [lbra_pkg::DATA_W-1:0]         req_alloc_size,
   input  logic [lbra_pkg::ALIGN_W-1:0]        req_align_bytes,
   input  logic [lbra_pkg::DATA_W-1:0]         req_release_handle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lbra_pkg::DATA_W-1:0]         rsp_granted_handle,
   output logic [lbra_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lbra_pkg::LIVE_W-1:0]         rsp_live_count,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   `include "linear_buffer_range_allocator_unit_assert.svh"

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W  = 17;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SCAN_FL  = 4'd1;
   localparam logic [3:0] ST_SCAN_SL  = 4'd2;
   localparam logic [3:0] ST_SCAN_CHK = 4'd3;
   localparam logic [3:0] ST_HIT_MV   = 4'd4;
   localparam logic [3:0] ST_DIV_GO   = 4'd5;
   localparam logic [3:0] ST_DIV_WAIT = 4'd6;
   localparam logic [3:0] ST_BUMP     = 4'd7;
   localparam logic [3:0] ST_FREE_RD  = 4'd8;
   localparam logic [3:0] ST_FREE_CHK = 4'd9;

   logic [3:0]                       state_ff, state_in;
   logic [lbra_pkg::DATA_W-1:0]      buf_size_ff, buf_size_in;
   logic [lbra_pkg::DATA_W-1:0]      stack_top_ff, stack_top_in;
   logic [CNT_W-1:0]                 slots_used_ff, slots_used_in;
   logic [CNT_W-1:0]                 free_count_ff, free_count_in;
   logic [CNT_W-1:0]                 live_ff, live_in;
   logic [lbra_pkg::TAG_W-1:0]       tag_ctr_ff, tag_ctr_in;
   logic [CNT_W-1:0]                 scan_idx_ff, scan_idx_in;
   logic [SLOT_W-1:0]                cur_slot_ff, cur_slot_in;
   logic                             req_type_ff, req_type_in;
   logic [lbra_pkg::DATA_W-1:0]      size_ff, size_in;
   logic [lbra_pkg::ALIGN_W-1:0]     align_ff, align_in;
   logic [lbra_pkg::DATA_W-1:0]      handle_ff, handle_in;
   logic [lbra_pkg::DATA_W:0]        aligned_ff, aligned_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lbra_pkg::DATA_W-1:0]      rsp_handle_ff, rsp_handle_in;
   logic [lbra_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [lbra_pkg::LIVE_W-1:0]      rsp_live_ff, rsp_live_in;

   logic                             out_free;
   logic                             csr_wr;
   logic                             rem_start;
   logic                             rem_done;
   logic [lbra_pkg::ALIGN_W-1:0]     rem_value;
   logic [lbra_pkg::DATA_W+1:0]      bump_top;
   logic                             bump_ok;
   logic                             free_ok;

   // Free-list memory.
   logic [SLOT_W-1:0]                fl_mem [MAX_SLOTS];
   logic [SLOT_W-1:0]                fl_rd_ff;
   logic [SLOT_W-1:0]                fl_rd_addr;
   logic                             fl_wr_en;
   logic [SLOT_W-1:0]                fl_wr_addr;
   logic [SLOT_W-1:0]                fl_wr_data;

   // Slot store ports.
   logic [SLOT_W-1:0]                sm_rd_addr;
   logic [lbra_pkg::TAG_W-1:0]       sm_rd_tag;
   logic                             sm_rd_live;
   logic [lbra_pkg::DATA_W-1:0]      sm_rd_res;
   logic [SLOT_W-1:0]                sm_wr_addr;
   logic                             sm_meta_en;
   logic [lbra_pkg::TAG_W-1:0]       sm_wr_tag;
   logic                             sm_wr_live;
   logic                             sm_res_en;

   lbra_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (stack_top_ff),
      .divisor   (align_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   lbra_slot_mem #(
      .MAX_SLOTS (MAX_SLOTS),
      .SLOT_W    (SLOT_W)
   ) u_slot_mem (
      .clock       (clock),
      .rd_addr     (sm_rd_addr),
      .rd_tag      (sm_rd_tag),
      .rd_live     (sm_rd_live),
      .rd_reserved (sm_rd_res),
      .wr_addr     (sm_wr_addr),
      .wr_meta_en  (sm_meta_en),
      .wr_tag      (sm_wr_tag),
      .wr_live     (sm_wr_live),
      .wr_res_en   (sm_res_en),
      .wr_reserved (size_ff)
   );

   // Free-list memory with registered read.
   always_ff @(posedge clock) begin
      if (fl_wr_en) begin
         fl_mem[fl_wr_addr] <= fl_wr_data;
      end
      fl_rd_ff <= fl_mem[fl_rd_addr];
   end

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == lbra_pkg::CSR_BUFFER_SIZE);
   assign csr_prdata = (csr_paddr[2] == lbra_pkg::CSR_BUFFER_SIZE) ? buf_size_ff : '0;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Bump-path fit check and free-path validity check.
   assign bump_top = {1'b0, aligned_ff} + {2'b00, size_ff};
   assign bump_ok  = (bump_top < {2'b00, buf_size_ff}) &&
                     (CMP_W'(slots_used_ff) < CMP_W'(MAX_SLOTS));
   assign free_ok  = (CMP_W'(handle_ff[15:0]) < CMP_W'(slots_used_ff)) &&
                     (sm_rd_tag == handle_ff[31:16]) && sm_rd_live &&
                     (CMP_W'(free_count_ff) < CMP_W'(MAX_SLOTS));

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      buf_size_in   = csr_wr ? csr_pwdata : buf_size_ff;
      stack_top_in  = stack_top_ff;
      slots_used_in = slots_used_ff;
      free_count_in = free_count_ff;
      live_in       = live_ff;
      tag_ctr_in    = tag_ctr_ff;
      scan_idx_in   = scan_idx_ff;
      cur_slot_in   = cur_slot_ff;
      req_type_in   = req_type_ff;
      size_in       = size_ff;
      align_in      = align_ff;
      handle_in     = handle_ff;
      aligned_in    = aligned_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_live_in   = rsp_live_ff;
      rem_start     = 1'b0;
      fl_rd_addr    = scan_idx_ff[SLOT_W-1:0];
      fl_wr_en      = 1'b0;
      fl_wr_addr    = scan_idx_ff[SLOT_W-1:0];
      fl_wr_data    = fl_rd_ff;
      sm_rd_addr    = fl_rd_ff;
      sm_wr_addr    = cur_slot_ff;
      sm_meta_en    = 1'b0;
      sm_wr_tag     = tag_ctr_ff;
      sm_wr_live    = 1'b1;
      sm_res_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_type_in = req_type;
               size_in     = req_alloc_size;
               align_in    = (req_align_bytes == '0) ? lbra_pkg::ALIGN_W'(1) : req_align_bytes;
               handle_in   = req_release_handle;
               scan_idx_in = '0;
               if (req_type == lbra_pkg::REQ_FREE) begin
                  state_in = ST_FREE_RD;
               end else if (free_count_ff != '0) begin
                  state_in = ST_SCAN_FL;
               end else begin
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_SCAN_FL: begin
            state_in = ST_SCAN_SL;
         end
         ST_SCAN_SL: begin
            cur_slot_in = fl_rd_ff;
            state_in    = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            // Fetch the last entry so it can fill the hole.
            fl_rd_addr = SLOT_W'(free_count_ff - CNT_W'(1));
            if (size_ff <= sm_rd_res) begin
               state_in = ST_HIT_MV;
            end else if (scan_idx_ff + CNT_W'(1) == free_count_ff) begin
               state_in = ST_DIV_GO;
            end else begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
               state_in    = ST_SCAN_FL;
            end
         end
         ST_HIT_MV: begin
            // Keep the last entry on the read port while the result side stalls.
            fl_rd_addr = SLOT_W'(free_count_ff - CNT_W'(1));
            if (out_free) begin
               fl_wr_en      = 1'b1;
               sm_meta_en    = 1'b1;
               free_count_in = free_count_ff - CNT_W'(1);
               live_in       = live_ff + CNT_W'(1);
               tag_ctr_in    = tag_ctr_ff + 16'd1;
               rsp_valid_in  = 1'b1;
               rsp_handle_in = {tag_ctr_ff, 16'(cur_slot_ff)};
               rsp_status_in = lbra_pkg::STATUS_OK;
               rsp_live_in   = lbra_pkg::LIVE_W'(live_ff + CNT_W'(1));
               state_in      = ST_IDLE;
            end
         end
         ST_DIV_GO: begin
            rem_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (rem_done) begin
               if (rem_value == '0) begin
                  aligned_in = {1'b0, stack_top_ff};
               end else begin
                  aligned_in = {1'b0, stack_top_ff} +
                               (lbra_pkg::DATA_W+1)'(align_ff - rem_value);
               end
               state_in = ST_BUMP;
            end
         end
         ST_BUMP: begin
            sm_wr_addr = slots_used_ff[SLOT_W-1:0];
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (bump_ok) begin
                  sm_meta_en    = 1'b1;
                  sm_res_en     = 1'b1;
                  slots_used_in = slots_used_ff + CNT_W'(1);
                  stack_top_in  = bump_top[lbra_pkg::DATA_W-1:0];
                  live_in       = live_ff + CNT_W'(1);
                  tag_ctr_in    = tag_ctr_ff + 16'd1;
                  rsp_handle_in = {tag_ctr_ff, 16'(slots_used_ff[SLOT_W-1:0])};
                  rsp_status_in = lbra_pkg::STATUS_OK;
                  rsp_live_in   = lbra_pkg::LIVE_W'(live_ff + CNT_W'(1));
               end else begin
                  rsp_handle_in = '0;
                  rsp_status_in = lbra_pkg::STATUS_NO_SPACE;
                  rsp_live_in   = lbra_pkg::LIVE_W'(live_ff);
               end
            end
         end
         ST_FREE_RD: begin
            sm_rd_addr  = handle_ff[SLOT_W-1:0];
            cur_slot_in = handle_ff[SLOT_W-1:0];
            state_in    = ST_FREE_CHK;
         end
         ST_FREE_CHK: begin
            // On a valid free, clear the live bit and push the slot on the free list.
            sm_rd_addr = cur_slot_ff;
            sm_wr_tag  = sm_rd_tag;
            sm_wr_live = 1'b0;
            fl_wr_addr = free_count_ff[SLOT_W-1:0];
            fl_wr_data = cur_slot_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               state_in      = ST_IDLE;
               if (free_ok) begin
                  sm_meta_en    = 1'b1;
                  fl_wr_en      = 1'b1;
                  free_count_in = free_count_ff + CNT_W'(1);
                  live_in       = live_ff - CNT_W'(1);
                  rsp_status_in = lbra_pkg::STATUS_OK;
                  rsp_live_in   = lbra_pkg::LIVE_W'(live_ff - CNT_W'(1));
               end else begin
                  rsp_status_in = lbra_pkg::STATUS_BAD_FREE;
                  rsp_live_in   = lbra_pkg::LIVE_W'(live_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         buf_size_ff   <= 32'd65536;
         stack_top_ff  <= '0;
         slots_used_ff <= '0;
         free_count_ff <= '0;
         live_ff       <= '0;
         tag_ctr_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         buf_size_ff   <= buf_size_in;
         stack_top_ff  <= stack_top_in;
         slots_used_ff <= slots_used_in;
         free_count_ff <= free_count_in;
         live_ff       <= live_in;
         tag_ctr_ff    <= tag_ctr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      scan_idx_ff   <= scan_idx_in;
      cur_slot_ff   <= cur_slot_in;
      req_type_ff   <= req_type_in;
      size_ff       <= size_in;
      align_ff      <= align_in;
      handle_ff     <= handle_in;
      aligned_ff    <= aligned_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_live_ff   <= rsp_live_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_handle = rsp_handle_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_live_count     = rsp_live_ff;

   // Every created slot is either live or on the free list.
   `LBRA_ASSERT_IMP(a_slot_balance, clock, reset, 1'b1,
      (CMP_W'(live_ff) + CMP_W'(free_count_ff)) == CMP_W'(slots_used_ff))
   // A reuse grant advances the generation tag by one.
   `LBRA_ASSERT_NXT(a_tag_step, clock, reset, (state_ff == ST_HIT_MV) && out_free,
      tag_ctr_ff == $past(tag_ctr_ff) + 16'd1)
   // The remainder is always below the alignment.
   `LBRA_ASSERT_IMP(a_rem_range, clock, reset, (state_ff == ST_DIV_WAIT) && rem_done,
      rem_value < align_ff)
   // Only free requests take the free path.
   `LBRA_ASSERT_IMP(a_free_path, clock, reset, state_ff == ST_FREE_CHK,
      req_type_ff == lbra_pkg::REQ_FREE)
endmodule
